[src/pixel_format_to_gray_or_bgr_top_macros.svh]
// Assertion helpers for the pixel format converter.
// Each check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef PIXEL_FORMAT_TO_GRAY_OR_BGR_TOP_MACROS_SVH
`define PIXEL_FORMAT_TO_GRAY_OR_BGR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define PFG_ASSERT_SAME(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("pfg same-cycle check failed");

`define PFG_ASSERT_NEXT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("pfg next-cycle check failed");

`else

`define PFG_ASSERT_SAME(label, ant, cons)

`define PFG_ASSERT_NEXT(label, ant, cons)

`endif

`endif

[src/pfg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pfg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	typedef enum logic [1:0] {
		REG_SRC_FORMAT,
		REG_DEST_FORMAT,
		REG_SWAP_RB
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SRC_GRAY8,
		SRC_BGR8,
		SRC_BGR16,
		SRC_BGRA8,
		SRC_BGR555,
		SRC_BGR565,
		SRC_CMYK8
	} src_fmt_t;

	typedef enum logic [1:0] {
		DST_GRAY,
		DST_THREE,
		DST_FOUR
	} dst_fmt_t;

	// BT.601 luma weights in Q14; blue takes the remainder so the sum is exactly 1.0
	localparam int          LUMA_SHIFT = 14;
	localparam logic [10:0] LUMA_B     = 11'd1868;
	localparam logic [13:0] LUMA_G     = 14'd9617;
	localparam logic [12:0] LUMA_R     = 13'd4899;
	localparam logic [29:0] LUMA_ROUND = 30'd8192;

	typedef struct packed {
		src_fmt_t src;
		dst_fmt_t dst;
		logic     swap_rb;
	} cfg_t;

	// For a CMYK source the channel fields hold (255 - x) * k, finished one stage later
	typedef struct packed {
		logic [15:0] b;
		logic [15:0] g;
		logic [15:0] r;
		logic [7:0]  a;
		logic [7:0]  k;
		logic        cmyk;
		logic        colour;
		logic        ok;
		dst_fmt_t    dst;
	} dec_t;

endpackage
`default_nettype wire

[src/pfg_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module pfg_decode (
	input  wire pfg_pkg::cfg_t cfg,
	input  wire logic [15:0]   chan_first,
	input  wire logic [15:0]   chan_second,
	input  wire logic [15:0]   chan_third,
	input  wire logic [7:0]    chan_fourth,
	input  wire logic [15:0]   packed_word,
	output pfg_pkg::dec_t      dec
);

	logic three_or_gray;
	logic swap_ok;
	logic [15:0] swap_tmp;

	assign three_or_gray = (cfg.dst == pfg_pkg::DST_GRAY) || (cfg.dst == pfg_pkg::DST_THREE);
	assign swap_ok = cfg.swap_rb && ((cfg.src == pfg_pkg::SRC_BGR8) ||
		(cfg.src == pfg_pkg::SRC_BGR16) || (cfg.src == pfg_pkg::SRC_BGRA8));

	always_comb begin
		dec        = '0;
		dec.dst    = cfg.dst;
		dec.colour = 1'b1;
		dec.ok     = three_or_gray;
		dec.k      = chan_fourth;
		case (cfg.src)
			pfg_pkg::SRC_GRAY8: begin
				dec.b      = {8'd0, chan_first[7:0]};
				dec.g      = {8'd0, chan_first[7:0]};
				dec.r      = {8'd0, chan_first[7:0]};
				dec.colour = 1'b0;
			end
			pfg_pkg::SRC_BGR8, pfg_pkg::SRC_BGRA8: begin
				dec.b = {8'd0, chan_first[7:0]};
				dec.g = {8'd0, chan_second[7:0]};
				dec.r = {8'd0, chan_third[7:0]};
				dec.a = chan_fourth;
				if (cfg.src == pfg_pkg::SRC_BGRA8 && cfg.dst == pfg_pkg::DST_FOUR) begin
					dec.ok = 1'b1;
				end
			end
			pfg_pkg::SRC_BGR16: begin
				dec.b = chan_first;
				dec.g = chan_second;
				dec.r = chan_third;
			end
			pfg_pkg::SRC_BGR555: begin
				dec.b = {8'd0, packed_word[4:0], 3'd0};
				dec.g = {8'd0, packed_word[9:5], 3'd0};
				dec.r = {8'd0, packed_word[14:10], 3'd0};
			end
			pfg_pkg::SRC_BGR565: begin
				dec.b = {8'd0, packed_word[4:0], 3'd0};
				dec.g = {8'd0, packed_word[10:5], 2'd0};
				dec.r = {8'd0, packed_word[15:11], 3'd0};
			end
			pfg_pkg::SRC_CMYK8: begin
				// blue comes from yellow and red from cyan
				dec.cmyk = 1'b1;
				dec.b    = {8'd0, ~chan_third[7:0]} * {8'd0, chan_fourth};
				dec.g    = {8'd0, ~chan_second[7:0]} * {8'd0, chan_fourth};
				dec.r    = {8'd0, ~chan_first[7:0]} * {8'd0, chan_fourth};
			end
			default: begin
				dec.ok = 1'b0;
			end
		endcase
		swap_tmp = dec.b;
		if (swap_ok) begin
			dec.b = dec.r;
			dec.r = swap_tmp;
		end
	end

endmodule
`default_nettype wire

[src/pixel_format_to_gray_or_bgr_top.sv]
// Pixel format converter, one pixel per transfer.
// Input stream s_*: tdata carries chan_first, chan_second, chan_third, chan_fourth and
// packed_word from bit 0 up. Output stream m_*: tdata carries out_first, out_second,
// out_third and out_alpha, tuser carries the unsupported flag.
// Configuration channel cfg_*: index 0 source format, 1 destination format, 2 red/blue
// swap; cfg_ready is always high and writes to other indexes are dropped. Change the
// registers only while no pixel is in flight.
// Three register stages: decode and CMYK products, CMYK finish and luma products, luma
// sum and output select; the last is the output register. m_tvalid rises once an input
// transfer has passed all three, and with m_tready high the output transfer is taken as
// soon as m_tvalid is set. Throughput is one pixel per cycle while m_tready stays high.
// When the receiver stalls, each stage holds while the one after it is full; empty stages
// still fill, so s_tready drops only once all three stages hold a pixel.
// Reset clears all valid bits and loads source bgr8, destination gray, no swap.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_format_to_gray_or_bgr_top_macros.svh"
module pixel_format_to_gray_or_bgr_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// chan_first[15:0], chan_second[31:16], chan_third[47:32], chan_fourth[55:48],
	// packed_word[71:56]
	input  wire logic [71:0]                      s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// out_first[15:0], out_second[31:16], out_third[47:32], out_alpha[55:48]
	output logic [55:0]                           m_tdata,
	// unsupported[0]
	output logic [0:0]                            m_tuser,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pfg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	pfg_pkg::cfg_t cfg_q;
	pfg_pkg::dec_t dec;

	logic rdy1, rdy2, rdy3;
	logic v1_s1, v2_s2, v3_s3;

	pfg_pkg::dec_t dec_s1;

	logic [15:0]        b_s2, g_s2, r_s2;
	logic [7:0]         a_s2;
	logic [26:0]        pb_s2;
	logic [29:0]        pg_s2;
	logic [28:0]        pr_s2;
	logic               ok_s2, colour_s2;
	pfg_pkg::dst_fmt_t  dst_s2;

	logic [15:0] first_s3, second_s3, third_s3;
	logic [7:0]  alpha_s3;
	logic        unsup_s3;

	logic [15:0] b_d, g_d, r_d;
	logic [29:0] sum_d;
	logic [15:0] luma_d;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src     <= pfg_pkg::SRC_BGR8;
			cfg_q.dst     <= pfg_pkg::DST_GRAY;
			cfg_q.swap_rb <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (pfg_pkg::cfg_reg_t'(cfg_index))
				pfg_pkg::REG_SRC_FORMAT:  cfg_q.src     <= pfg_pkg::src_fmt_t'(cfg_data);
				pfg_pkg::REG_DEST_FORMAT: cfg_q.dst     <= pfg_pkg::dst_fmt_t'(cfg_data[1:0]);
				pfg_pkg::REG_SWAP_RB:     cfg_q.swap_rb <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline handshake: a stage advances when the one after it is empty or moving
	assign rdy3     = !v3_s3 || m_tready;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= s_tvalid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
		end
	end

	// stage 1: unpack and CMYK products
	pfg_decode u_decode (
		.cfg         (cfg_q),
		.chan_first  (s_tdata[15:0]),
		.chan_second (s_tdata[31:16]),
		.chan_third  (s_tdata[47:32]),
		.chan_fourth (s_tdata[55:48]),
		.packed_word (s_tdata[71:56]),
		.dec         (dec)
	);

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			dec_s1 <= dec;
		end
	end

	// stage 2: finish CMYK, luma products
	always_comb begin
		b_d = dec_s1.b;
		g_d = dec_s1.g;
		r_d = dec_s1.r;
		if (dec_s1.cmyk) begin
			b_d = {8'd0, dec_s1.k - dec_s1.b[15:8]};
			g_d = {8'd0, dec_s1.k - dec_s1.g[15:8]};
			r_d = {8'd0, dec_s1.k - dec_s1.r[15:8]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v1_s1) begin
			b_s2      <= b_d;
			g_s2      <= g_d;
			r_s2      <= r_d;
			a_s2      <= dec_s1.a;
			pb_s2     <= 27'(b_d) * 27'(pfg_pkg::LUMA_B);
			pg_s2     <= 30'(g_d) * 30'(pfg_pkg::LUMA_G);
			pr_s2     <= 29'(r_d) * 29'(pfg_pkg::LUMA_R);
			ok_s2     <= dec_s1.ok;
			colour_s2 <= dec_s1.colour;
			dst_s2    <= dec_s1.dst;
		end
	end

	// stage 3: luma sum and output select
	assign sum_d  = 30'(pb_s2) + pg_s2 + 30'(pr_s2) + pfg_pkg::LUMA_ROUND;
	assign luma_d = sum_d[pfg_pkg::LUMA_SHIFT +: 16];

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			first_s3  <= '0;
			second_s3 <= '0;
			third_s3  <= '0;
			alpha_s3  <= '0;
			unsup_s3  <= !ok_s2;
			if (ok_s2) begin
				if (dst_s2 == pfg_pkg::DST_GRAY) begin
					first_s3 <= colour_s2 ? luma_d : b_s2;
				end else begin
					first_s3  <= b_s2;
					second_s3 <= g_s2;
					third_s3  <= r_s2;
					if (dst_s2 == pfg_pkg::DST_FOUR) alpha_s3 <= a_s2;
				end
			end
		end
	end

	assign m_tvalid = v3_s3;
	assign m_tdata  = {alpha_s3, third_s3, second_s3, first_s3};
	assign m_tuser  = unsup_s3;

	`PFG_ASSERT_SAME(a_unsup_zero, v3_s3 && unsup_s3, m_tdata == '0)
	`PFG_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v1_s1)
	`PFG_ASSERT_NEXT(a_s2_holds, v2_s2 && !rdy3, v2_s2 && $stable(pg_s2) && $stable(b_s2))
	`PFG_ASSERT_SAME(a_full_stall, v1_s1 && v2_s2 && v3_s3 && !m_tready, !s_tready)

endmodule
`default_nettype wire
